// ===== rtl/hgcd_pkg.sv =====
// ----------------------------------------------------------------------------
// hgcd_pkg: shared types and constants of the great-circle distance core
// Fixed-point formats, lane structs of the cell chains and the arctangent table.
// ----------------------------------------------------------------------------
package hgcd_pkg;

  // Width of the CORDIC x/y datapath (30 fraction bits plus growth and sign).
  localparam int X_W  = 34;
  // Width of the CORDIC angle accumulator (32 fraction bits).
  localparam int Z_W  = 36;
  // Width of the square-root remainder and root registers.
  localparam int SQ_W = 62;
  // Input angle field width and output field widths.
  localparam int IN_W   = 32;
  localparam int DIST_W = 29;
  localparam int R_W    = 23;

  localparam logic [32:0] HALF_PI_Q32    = 33'd6746518852;
  localparam logic [31:0] QUARTER_PI_Q32 = 32'd3373259426;
  localparam logic [29:0] GAIN_Q30       = 30'd652032874;
  localparam logic [R_W-1:0]    RADIUS_RESET = 23'd6371009;
  localparam logic [DIST_W-1:0] DIST_MAX     = 29'd536870911;

  typedef struct packed {
    logic signed [X_W-1:0] x;
    logic signed [X_W-1:0] y;
    logic signed [Z_W-1:0] z;
    logic [1:0]            quad;
    logic                  neg;
  } rot_t;

  typedef struct packed {
    logic [SQ_W-1:0] v_h;
    logic [SQ_W-1:0] r_h;
    logic [SQ_W-1:0] v_c;
    logic [SQ_W-1:0] r_c;
    logic            anti;
  } sq_t;

  typedef struct packed {
    logic signed [X_W-1:0] x;
    logic signed [X_W-1:0] y;
    logic signed [Z_W-1:0] z;
    logic                  anti;
  } vec_t;

  // Shift-subtract division, used only while the table is elaborated.
  function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(2^-i) with 32 fraction bits, from the alternating arctangent series.
  function automatic longint atan_q32(int unsigned i);
    longint      acc;
    longint      term;
    bit          neg;
    int unsigned n;
    acc = 0;
    neg = 1'b0;
    n   = 1;
    if (i == 0) begin
      return longint'(QUARTER_PI_Q32);
    end
    while (i * n <= 62) begin
      term = longint'(udiv64(64'd1 << (62 - i * n), 64'(n)));
      acc  = neg ? acc - term : acc + term;
      neg  = !neg;
      n    = n + 2;
    end
    return (acc + (64'sd1 <<< 29)) >>> 30;
  endfunction

endpackage

// ===== rtl/hgcd_divcell.sv =====
// ----------------------------------------------------------------------------
// hgcd_divcell: one restoring-division cell of the quadrant reduction
// Takes one quotient bit of angle / (pi/2) and keeps the two low quotient bits.
// ----------------------------------------------------------------------------
module hgcd_divcell #(
  parameter int W = 35,
  parameter int K = 0
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] r_i,
  input  logic [1:0]   q_i,
  input  logic         neg_i,
  output logic [W-1:0] r_o,
  output logic [1:0]   q_o,
  output logic         neg_o
);
  import hgcd_pkg::*;

  localparam logic [W-1:0] DIVISOR = {{(W-33){1'b0}}, HALF_PI_Q32} << K;

  logic         take;
  logic [W-1:0] r_d;
  logic [1:0]   q_d;
  logic [W-1:0] r_q;
  logic [1:0]   q_q;
  logic         neg_q;

  always_comb begin
    take = (r_i >= DIVISOR);
    r_d  = take ? r_i - DIVISOR : r_i;
    q_d  = q_i;
    if (K == 0) begin
      q_d[0] = take;
    end else if (K == 1) begin
      q_d[1] = take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q   <= r_d;
      q_q   <= q_d;
      neg_q <= neg_i;
    end
  end

  assign r_o   = r_q;
  assign q_o   = q_q;
  assign neg_o = neg_q;

endmodule

// ===== rtl/hgcd_rotcell.sv =====
// ----------------------------------------------------------------------------
// hgcd_rotcell: one rotation-mode CORDIC cell
// Rotates (x, y) toward the residual angle by atan(2^-STAGE).
// ----------------------------------------------------------------------------
module hgcd_rotcell #(
  parameter int unsigned STAGE = 0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  hgcd_pkg::rot_t c_i,
  output hgcd_pkg::rot_t c_o
);
  import hgcd_pkg::*;

  localparam logic signed [Z_W-1:0] ATAN = Z_W'(atan_q32(STAGE));

  logic signed [X_W-1:0] x;
  logic signed [X_W-1:0] y;
  logic signed [Z_W-1:0] z;
  logic signed [X_W-1:0] dx;
  logic signed [X_W-1:0] dy;
  rot_t                  c_d;
  rot_t                  c_q;

  always_comb begin
    x  = c_i.x;
    y  = c_i.y;
    z  = c_i.z;
    dx = y >>> STAGE;
    dy = x >>> STAGE;
    c_d = c_i;
    if (z >= 0) begin
      c_d.x = x - dx;
      c_d.y = y + dy;
      c_d.z = z - ATAN;
    end else begin
      c_d.x = x + dx;
      c_d.y = y - dy;
      c_d.z = z + ATAN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= c_d;
    end
  end

  assign c_o = c_q;

endmodule

// ===== rtl/hgcd_sqrtcell.sv =====
// ----------------------------------------------------------------------------
// hgcd_sqrtcell: one digit cell of the paired integer square roots
// Settles one root bit of sqrt(h) and of sqrt(1-h) side by side.
// ----------------------------------------------------------------------------
module hgcd_sqrtcell #(
  parameter int K = 0
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  hgcd_pkg::sq_t c_i,
  output hgcd_pkg::sq_t c_o
);
  import hgcd_pkg::*;

  localparam logic [SQ_W-1:0] BIT = {{(SQ_W-1){1'b0}}, 1'b1} << (2 * K);

  logic [SQ_W-1:0] t_h;
  logic [SQ_W-1:0] t_c;
  sq_t             c_d;
  sq_t             c_q;

  always_comb begin
    c_d = c_i;
    t_h = c_i.r_h + BIT;
    t_c = c_i.r_c + BIT;
    if (c_i.v_h >= t_h) begin
      c_d.v_h = c_i.v_h - t_h;
      c_d.r_h = (c_i.r_h >> 1) + BIT;
    end else begin
      c_d.r_h = c_i.r_h >> 1;
    end
    if (c_i.v_c >= t_c) begin
      c_d.v_c = c_i.v_c - t_c;
      c_d.r_c = (c_i.r_c >> 1) + BIT;
    end else begin
      c_d.r_c = c_i.r_c >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= c_d;
    end
  end

  assign c_o = c_q;

endmodule

// ===== rtl/hgcd_veccell.sv =====
// ----------------------------------------------------------------------------
// hgcd_veccell: one vectoring-mode CORDIC cell
// Drives y toward zero and accumulates the angle of (x, y).
// ----------------------------------------------------------------------------
module hgcd_veccell #(
  parameter int unsigned STAGE = 0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  hgcd_pkg::vec_t c_i,
  output hgcd_pkg::vec_t c_o
);
  import hgcd_pkg::*;

  localparam logic signed [Z_W-1:0] ATAN = Z_W'(atan_q32(STAGE));

  logic signed [X_W-1:0] x;
  logic signed [X_W-1:0] y;
  logic signed [Z_W-1:0] z;
  logic signed [X_W-1:0] dx;
  logic signed [X_W-1:0] dy;
  vec_t                  c_d;
  vec_t                  c_q;

  always_comb begin
    x  = c_i.x;
    y  = c_i.y;
    z  = c_i.z;
    dx = y >>> STAGE;
    dy = x >>> STAGE;
    c_d = c_i;
    if (y >= 0) begin
      c_d.x = x + dx;
      c_d.y = y - dy;
      c_d.z = z + ATAN;
    end else begin
      c_d.x = x - dx;
      c_d.y = y + dy;
      c_d.z = z - ATAN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= c_d;
    end
  end

  assign c_o = c_q;

endmodule

// ===== rtl/haversine_great_circle_distance_core.sv =====
// Throughput: one word per cycle while the output is not stalled; all cells advance together.
// The two CORDIC chains and the 31-cell square-root chain set the latency.
// Reset clears all valid flags and loads the sphere radius with 6371009 m.
// ----------------------------------------------------------------------------
// haversine_great_circle_distance_core: great-circle distance on a sphere
// Haversine distance between two positions, built as chains of small cells.
// ----------------------------------------------------------------------------
module haversine_great_circle_distance_core #(
  parameter int ANGLE_FRAC_BITS = 29,
  parameter int CORDIC_STAGES   = 28
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Position pair stream.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // From bit 0 up: lat_a[31:0], lon_a[63:32], lat_b[95:64], lon_b[127:96].
  input  logic [127:0] s_axis_tdata,
  // Distance stream.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // From bit 0 up: distance[28:0], then three zero bits.
  output logic [31:0]  m_axis_tdata,
  // From bit 0 up: antipodal[0].
  output logic [0:0]   m_axis_tuser,
  // Sphere radius register write channel.
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [hgcd_pkg::R_W-1:0] cfg_data_i
);
  import hgcd_pkg::*;

  // Width of a scaled input angle with 32 fraction bits, and the number of
  // quotient bits needed to reduce it by multiples of pi/2.
  localparam int AW  = 64 - ANGLE_FRAC_BITS;
  localparam int QW  = AW - 32;
  localparam int PW  = 2 * X_W;
  localparam int LAT = 38 + QW + 2 * CORDIC_STAGES;
  localparam int LANES = 4;

  // --------------------------------------------------------------------------
  // Flow control. All cells move together on advance. The output side has a
  // head register and one skid register, so a single waiting result word
  // never blocks the input.
  // --------------------------------------------------------------------------
  logic advance;
  logic push;
  logic pop;
  logic [LAT-1:0] vld_q;

  logic                head_vld_q;
  logic                skid_vld_q;
  logic [DIST_W-1:0]   head_dist_q;
  logic                head_anti_q;
  logic [DIST_W-1:0]   skid_dist_q;
  logic                skid_anti_q;
  logic [DIST_W-1:0]   dist_d;

  logic [R_W-1:0] radius_q;

  assign pop     = head_vld_q && m_axis_tready;
  assign advance = !skid_vld_q || pop;
  assign push    = vld_q[LAT-1] && advance;

  assign s_axis_tready = advance;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
    end else if (cfg_valid_i) begin
      radius_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // --------------------------------------------------------------------------
  // Input stage: the two half differences and the two latitudes are scaled
  // to 32 fraction bits; the magnitude plus pi/4 feeds the rounding division
  // that picks the nearest multiple of pi/2.
  // --------------------------------------------------------------------------
  logic signed [IN_W-1:0] lat_a;
  logic signed [IN_W-1:0] lon_a;
  logic signed [IN_W-1:0] lat_b;
  logic signed [IN_W-1:0] lon_b;
  logic signed [IN_W:0]   dlat;
  logic signed [IN_W:0]   dlon;
  logic signed [AW-1:0]   ang [LANES];
  logic [AW-1:0]          mag [LANES];
  logic [AW-1:0]          u_q [LANES];
  logic                   neg_q [LANES];

  always_comb begin
    lat_a = s_axis_tdata[31:0];
    lon_a = s_axis_tdata[63:32];
    lat_b = s_axis_tdata[95:64];
    lon_b = s_axis_tdata[127:96];
    dlat  = {lat_b[IN_W-1], lat_b} - {lat_a[IN_W-1], lat_a};
    dlon  = {lon_b[IN_W-1], lon_b} - {lon_a[IN_W-1], lon_a};
    ang[0] = {{(AW-33){dlat[IN_W]}}, dlat} <<< (31 - ANGLE_FRAC_BITS);
    ang[1] = {{(AW-33){dlon[IN_W]}}, dlon} <<< (31 - ANGLE_FRAC_BITS);
    ang[2] = {{(AW-32){lat_a[IN_W-1]}}, lat_a} <<< (32 - ANGLE_FRAC_BITS);
    ang[3] = {{(AW-32){lat_b[IN_W-1]}}, lat_b} <<< (32 - ANGLE_FRAC_BITS);
    for (int l = 0; l < LANES; l++) begin
      mag[l] = ang[l][AW-1] ? AW'(-ang[l]) : AW'(ang[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int l = 0; l < LANES; l++) begin
        u_q[l]   <= mag[l] + {{(AW-32){1'b0}}, QUARTER_PI_Q32};
        neg_q[l] <= ang[l][AW-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Per lane: reduction chain, then the rotation CORDIC chain, then the
  // quadrant and sign are folded back into sine and cosine.
  // --------------------------------------------------------------------------
  logic [AW-1:0]         r_c   [LANES][QW+1];
  logic [1:0]            q_c   [LANES][QW+1];
  logic                  n_c   [LANES][QW+1];
  rot_t                  rot_c [LANES][CORDIC_STAGES+1];
  logic signed [X_W-1:0] sin_w [LANES];
  logic signed [X_W-1:0] cos_w [LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    assign r_c[l][0] = u_q[l];
    assign q_c[l][0] = 2'b00;
    assign n_c[l][0] = neg_q[l];

    for (genvar j = 0; j < QW; j++) begin : g_div
      hgcd_divcell #(
        .W (AW),
        .K (QW - 1 - j)
      ) u_div (
        .clk_i (clk_i),
        .en_i  (advance),
        .r_i   (r_c[l][j]),
        .q_i   (q_c[l][j]),
        .neg_i (n_c[l][j]),
        .r_o   (r_c[l][j+1]),
        .q_o   (q_c[l][j+1]),
        .neg_o (n_c[l][j+1])
      );
    end

    // The remainder minus pi/4 is the residual angle within +-pi/4.
    always_comb begin
      rot_c[l][0].x    = {{(X_W-30){1'b0}}, GAIN_Q30};
      rot_c[l][0].y    = '0;
      rot_c[l][0].z    = $signed({{(Z_W-33){1'b0}}, r_c[l][QW][32:0]})
                       - $signed({{(Z_W-32){1'b0}}, QUARTER_PI_Q32});
      rot_c[l][0].quad = q_c[l][QW];
      rot_c[l][0].neg  = n_c[l][QW];
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
      hgcd_rotcell #(
        .STAGE (i)
      ) u_rot (
        .clk_i (clk_i),
        .en_i  (advance),
        .c_i   (rot_c[l][i]),
        .c_o   (rot_c[l][i+1])
      );
    end

    always_comb begin
      logic signed [X_W-1:0] rx;
      logic signed [X_W-1:0] ry;
      logic signed [X_W-1:0] s;
      logic signed [X_W-1:0] c;
      rx = rot_c[l][CORDIC_STAGES].x;
      ry = rot_c[l][CORDIC_STAGES].y;
      case (rot_c[l][CORDIC_STAGES].quad)
        2'd0: begin
          s = ry;
          c = rx;
        end
        2'd1: begin
          s = rx;
          c = -ry;
        end
        2'd2: begin
          s = -ry;
          c = -rx;
        end
        default: begin
          s = -rx;
          c = ry;
        end
      endcase
      sin_w[l] = rot_c[l][CORDIC_STAGES].neg ? -s : s;
      cos_w[l] = c;
    end
  end

  // --------------------------------------------------------------------------
  // Haversine sum: h = s1^2 + round(s2*ca) * round(s2*cb), 60 fraction bits.
  // --------------------------------------------------------------------------
  logic signed [X_W-1:0] s1_q;
  logic signed [X_W-1:0] s2_q;
  logic signed [X_W-1:0] ca_q;
  logic signed [X_W-1:0] cb_q;
  logic signed [PW-1:0]  p1_q;
  logic signed [PW-1:0]  p1b_q;
  logic signed [PW-1:0]  p1c_q;
  logic signed [PW-1:0]  pa_q;
  logic signed [PW-1:0]  pb_q;
  logic signed [PW-1:0]  ra_full;
  logic signed [PW-1:0]  rb_full;
  logic signed [X_W-1:0] ra_q;
  logic signed [X_W-1:0] rb_q;
  logic signed [PW-1:0]  pab_q;
  logic signed [PW-1:0]  h_w;
  logic                  anti_w;
  logic [SQ_W-1:0]       hc_w;
  sq_t                   sq_c [32];

  localparam logic signed [PW-1:0] RND30  = PW'(64'sd536870912);
  localparam logic signed [PW-1:0] ONE_60 = PW'(64'sd1152921504606846976);

  always_comb begin
    ra_full = (pa_q + RND30) >>> 30;
    rb_full = (pb_q + RND30) >>> 30;
    h_w     = p1c_q + pab_q;
    anti_w  = !h_w[PW-1] && (h_w >= ONE_60);
    hc_w    = h_w[PW-1] ? '0 : {1'b0, h_w[SQ_W-2:0]};
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_q  <= sin_w[0];
      s2_q  <= sin_w[1];
      ca_q  <= cos_w[2];
      cb_q  <= cos_w[3];
      p1_q  <= s1_q * s1_q;
      pa_q  <= s2_q * ca_q;
      pb_q  <= s2_q * cb_q;
      p1b_q <= p1_q;
      ra_q  <= ra_full[X_W-1:0];
      rb_q  <= rb_full[X_W-1:0];
      p1c_q <= p1b_q;
      pab_q <= ra_q * rb_q;
      sq_c[0].v_h  <= hc_w;
      sq_c[0].r_h  <= '0;
      sq_c[0].v_c  <= ONE_60[SQ_W-1:0] - hc_w;
      sq_c[0].r_c  <= '0;
      sq_c[0].anti <= anti_w;
    end
  end

  // --------------------------------------------------------------------------
  // Square roots of h and 1-h, one root bit per cell, 30 fraction bits.
  // --------------------------------------------------------------------------
  for (genvar j = 0; j < 31; j++) begin : g_sqrt
    hgcd_sqrtcell #(
      .K (30 - j)
    ) u_sqrt (
      .clk_i (clk_i),
      .en_i  (advance),
      .c_i   (sq_c[j]),
      .c_o   (sq_c[j+1])
    );
  end

  // --------------------------------------------------------------------------
  // Half central angle atan2(sqrt(h), sqrt(1-h)) by the vectoring chain.
  // --------------------------------------------------------------------------
  vec_t vec_c [CORDIC_STAGES+1];

  always_comb begin
    vec_c[0].x    = {{(X_W-31){1'b0}}, sq_c[31].r_c[30:0]};
    vec_c[0].y    = {{(X_W-31){1'b0}}, sq_c[31].r_h[30:0]};
    vec_c[0].z    = '0;
    vec_c[0].anti = sq_c[31].anti;
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
    hgcd_veccell #(
      .STAGE (i)
    ) u_vec (
      .clk_i (clk_i),
      .en_i  (advance),
      .c_i   (vec_c[i]),
      .c_o   (vec_c[i+1])
    );
  end

  // --------------------------------------------------------------------------
  // Scaling: distance = (z * R + 2^26) >> 27, saturated. An antipodal pair
  // takes pi/2 as its half angle, and a negative residue counts as zero.
  // --------------------------------------------------------------------------
  logic [33:0]      zc_w;
  logic [56:0]      dprod_q;
  logic             danti_q;
  logic [57:0]      dsum_w;
  logic [30:0]      dq_w;
  logic signed [Z_W-1:0] zf_w;

  always_comb begin
    zf_w = vec_c[CORDIC_STAGES].z;
    if (vec_c[CORDIC_STAGES].anti) begin
      zc_w = {1'b0, HALF_PI_Q32};
    end else if (zf_w < 0) begin
      zc_w = '0;
    end else begin
      zc_w = zf_w[33:0];
    end
    dsum_w = {1'b0, dprod_q} + 58'd67108864;
    dq_w   = dsum_w[57:27];
    dist_d = (dq_w > {2'b00, DIST_MAX}) ? DIST_MAX : dq_w[DIST_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      dprod_q <= zc_w * radius_q;
      danti_q <= vec_c[CORDIC_STAGES].anti;
    end
  end

  // --------------------------------------------------------------------------
  // Output head and skid registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (pop) begin
        head_vld_q <= 1'b1;
        skid_vld_q <= push;
      end
    end else if (!head_vld_q || pop) begin
      head_vld_q <= push;
    end else begin
      skid_vld_q <= push;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (pop) begin
        head_dist_q <= skid_dist_q;
        head_anti_q <= skid_anti_q;
        skid_dist_q <= dist_d;
        skid_anti_q <= danti_q;
      end
    end else if (!head_vld_q || pop) begin
      head_dist_q <= dist_d;
      head_anti_q <= danti_q;
    end else begin
      skid_dist_q <= dist_d;
      skid_anti_q <= danti_q;
    end
  end

  assign m_axis_tvalid = head_vld_q;
  assign m_axis_tdata  = {3'b000, head_dist_q};
  assign m_axis_tuser  = head_anti_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // The skid register only fills behind an occupied head register.
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_vld_q |-> head_vld_q)
    else $error("skid word present without head word");

  // A finished word at the end of the chain is kept while the chain stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (vld_q[LAT-1] && !advance) |=> vld_q[LAT-1])
    else $error("result word lost during stall");

  // The chain only stalls when the skid register is occupied.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !advance |-> skid_vld_q)
    else $error("stall without a full output buffer");

endmodule
